/* rtl/core/bpl_pkg.sv */
`timescale 1ns / 1ps

package bpl_pkg;

  localparam int NOW_BITS    = 32;
  localparam int TAG_BITS    = 4;
  localparam int PERIOD_BITS = 16;
  localparam int REPEAT_BITS = 8;
  localparam int SPAN_BITS   = PERIOD_BITS + REPEAT_BITS;
  localparam int IN_BITS     = NOW_BITS + 2 * TAG_BITS;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_LOW  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_HIGH = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_REPEATS    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAUSE      = 3'd4;

  localparam int LEVEL_HIGH_RESET = 4095;
  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET  = 16'd2000;
  localparam logic [REPEAT_BITS-1:0] REPEATS_RESET = 8'd3;
  localparam logic [PERIOD_BITS-1:0] PAUSE_RESET   = 16'd1000;

endpackage

/* rtl/core/bpl_serdiv.sv */
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module bpl_serdiv #(
  parameter int DW = 28,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CW = $clog2(DW);

  logic [DW-1:0] dvd;
  logic [VW-1:0] dsr;
  logic [VW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          busy;

  logic [VW:0]   rem_sh;
  logic          ge;
  logic [VW:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem, dvd[DW-1]};
    ge      = rem_sh >= {1'b0, dsr};
    rem_sub = rem_sh - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == CW'(DW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DW-2:0], ge};
      rem <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule

/* rtl/core/breath_then_pause_led_pattern.sv */
`timescale 1ns / 1ps

// Breath-then-pause LED level generator.
// Input stream s_*: one word per refresh, carrying a millisecond timestamp and a
// board/channel tag. Output stream m_*: one word per input word, in order, with
// the tag and the level to drive. Config channel cfg_*: index/data writes to
// level_low, level_high, breath_period_ms, breath_repeats, pause_ms; always
// ready outside reset, to be written only while no word is in flight.
// One word is processed at a time. Time per word is set by a shift-add
// multiplier and one bit-serial divider (one bit per cycle, 16+LEVEL_BITS
// bits): the multiplier forms the breath span; a pause or idle phase then
// ends the word, a breath runs the divider for the phase, the multiplier to
// scale it and the divider for the level. s_tready rises again once the
// result sits in the output register, so the next word is taken while the
// previous result waits. A stalled m_tready holds m_tdata; a finished result
// waits inside until the output register frees. Reset clears the
// cycle start time, loads the default configuration and empties the pipeline.
module breath_then_pause_led_pattern
  import bpl_pkg::*;
#(
  parameter int LEVEL_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // now_ms[31:0], board_index[35:32], channel_index[39:36]
  input  logic [IN_BITS-1:0]       s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // out_board[3:0], out_channel[7:4], level[8+LEVEL_BITS-1:8], zero pad
  output logic [((2*TAG_BITS+LEVEL_BITS+7)/8)*8-1:0] m_tdata,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int PW    = PERIOD_BITS + LEVEL_BITS;
  localparam int OUT_W = ((2 * TAG_BITS + LEVEL_BITS + 7) / 8) * 8;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SPAN  = 6'b000010,
    ST_PHASE = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_MAP   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic [LEVEL_BITS-1:0]  level_low;
  logic [LEVEL_BITS-1:0]  level_high;
  logic [PERIOD_BITS-1:0] period;
  logic [REPEAT_BITS-1:0] repeats;
  logic [PERIOD_BITS-1:0] pause;
  logic [NOW_BITS-1:0]    cycle_start;

  logic [NOW_BITS-1:0]    now_r;
  logic [NOW_BITS-1:0]    elapsed0;
  logic [TAG_BITS-1:0]    tag_board;
  logic [TAG_BITS-1:0]    tag_ch;
  logic [PW-1:0]          mcand;
  logic [LEVEL_BITS-1:0]  mplier;
  logic [PW-1:0]          acc;
  logic [PERIOD_BITS-1:0] den_r;
  logic [LEVEL_BITS-1:0]  base_r;
  logic                   up_r;
  logic [LEVEL_BITS-1:0]  lvl_r;
  logic                   out_valid;
  logic [OUT_W-1:0]       out_data;

  logic                   mul_busy;
  logic [SPAN_BITS:0]     cyc_len;
  logic                   restart;
  logic                   in_breath;

  logic [PERIOD_BITS-1:0] half;
  logic [PERIOD_BITS-1:0] phase;
  logic                   rising;
  logic [PERIOD_BITS-1:0] off;
  logic [PERIOD_BITS-1:0] den;
  logic [LEVEL_BITS-1:0]  seg_base;
  logic [LEVEL_BITS-1:0]  seg_target;
  logic                   seg_up;
  logic [LEVEL_BITS-1:0]  seg_mag;

  logic                   div_start;
  logic [PW-1:0]          div_dividend;
  logic [PERIOD_BITS-1:0] div_divisor;
  logic                   div_done;
  logic [PW-1:0]          div_quo;
  logic [PERIOD_BITS-1:0] div_rem;

  logic                   out_free;

  assign s_tready  = (state == ST_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;
  assign out_free  = !out_valid || m_tready;

  always_comb begin
    mul_busy  = mplier != '0;
    cyc_len   = (SPAN_BITS+1)'(acc[SPAN_BITS-1:0]) + (SPAN_BITS+1)'(pause);
    restart   = elapsed0 >= NOW_BITS'(cyc_len);
    in_breath = restart ? (acc[SPAN_BITS-1:0] != '0)
                        : (elapsed0 < NOW_BITS'(acc[SPAN_BITS-1:0]));

    half       = period >> 1;
    phase      = div_rem;
    rising     = phase <= half;
    off        = rising ? phase : phase - half;
    den        = rising ? half : period - half;
    seg_base   = rising ? level_low : level_high;
    seg_target = rising ? level_high : level_low;
    seg_up     = seg_target >= seg_base;
    seg_mag    = seg_up ? seg_target - seg_base : seg_base - seg_target;

    div_start    = ((state == ST_SPAN) && !mul_busy && in_breath) ||
                   ((state == ST_SCALE) && !mul_busy);
    div_dividend = (state == ST_SPAN)
                 ? (restart ? '0 : PW'(elapsed0[SPAN_BITS-1:0])) : acc;
    div_divisor  = (state == ST_SPAN) ? period : den_r;
  end

  bpl_serdiv #(
    .DW (PW),
    .VW (PERIOD_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      level_low  <= '0;
      level_high <= LEVEL_BITS'(LEVEL_HIGH_RESET);
      period     <= PERIOD_RESET;
      repeats    <= REPEATS_RESET;
      pause      <= PAUSE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LEVEL_LOW:  level_low  <= cfg_data[LEVEL_BITS-1:0];
        REG_LEVEL_HIGH: level_high <= cfg_data[LEVEL_BITS-1:0];
        REG_PERIOD:     period     <= cfg_data[PERIOD_BITS-1:0];
        REG_REPEATS:    repeats    <= cfg_data[REPEAT_BITS-1:0];
        REG_PAUSE:      pause      <= cfg_data[PERIOD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cycle_start <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_SPAN;
          end
        end
        ST_SPAN: begin
          if (!mul_busy) begin
            if (restart) begin
              cycle_start <= now_r;
            end
            state <= in_breath ? ST_PHASE : ST_DONE;
          end
        end
        ST_PHASE: begin
          if (div_done) begin
            state <= (den == '0) ? ST_DONE : ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (!mul_busy) begin
            state <= ST_MAP;
          end
        end
        ST_MAP: begin
          if (div_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        now_r     <= s_tdata[NOW_BITS-1:0];
        elapsed0  <= s_tdata[NOW_BITS-1:0] - cycle_start;
        tag_board <= s_tdata[NOW_BITS +: TAG_BITS];
        tag_ch    <= s_tdata[NOW_BITS+TAG_BITS +: TAG_BITS];
        mcand     <= PW'(period);
        mplier    <= LEVEL_BITS'(repeats);
        acc       <= '0;
      end
      ST_SPAN, ST_SCALE: begin
        if (mul_busy) begin
          acc    <= acc + (mplier[0] ? mcand : '0);
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
        end else if (state == ST_SPAN && !in_breath) begin
          lvl_r <= level_low;
        end
      end
      ST_PHASE: begin
        if (div_done) begin
          mcand  <= PW'(off);
          mplier <= (den == '0) ? '0 : seg_mag;
          acc    <= '0;
          den_r  <= den;
          base_r <= seg_base;
          up_r   <= seg_up;
          lvl_r  <= level_low;
        end
      end
      ST_MAP: begin
        if (div_done) begin
          lvl_r <= up_r ? base_r + div_quo[LEVEL_BITS-1:0]
                        : base_r - div_quo[LEVEL_BITS-1:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_data <= OUT_W'({lvl_r, tag_ch, tag_board});
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/bpl_checker.sv */
`timescale 1ns / 1ps

module bpl_checker
  import bpl_pkg::*;
#(
  parameter int LEVEL_BITS = 12
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [IN_BITS-1:0]   s_tdata,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [((2*TAG_BITS+LEVEL_BITS+7)/8)*8-1:0] m_tdata
);

  logic [2*TAG_BITS-1:0] tag_q;

  always_ff @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      tag_q <= s_tdata[NOW_BITS +: 2*TAG_BITS];
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while one is in work");

  a_tag_follows: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (!$past(m_tvalid) || $past(m_tready))
      |-> m_tdata[2*TAG_BITS-1:0] == tag_q)
    else $error("output tag differs from last accepted tag");

endmodule

bind breath_then_pause_led_pattern bpl_checker #(
  .LEVEL_BITS (LEVEL_BITS)
) u_bpl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
